@@ rtl/core/igemv_pkg.sv @@
// Shared types and constants for the int4-weight GEMV tile.
// Item structs for both channels and the record passed along the row chain.
// No dependencies.
package igemv_pkg;

	localparam int ACT_ROWS  = 8;   // rows carried by the activation fields
	localparam int COL_SLOTS = 8;   // columns addressable by the column field
	localparam int ACC_W     = 32;
	localparam int ADDR_W    = 3;

	localparam logic [ADDR_W-1:0] ADDR_ACTIVE_ROWS  = 3'h0;
	localparam logic [3:0]        ACTIVE_ROWS_RESET = 4'd1;
	localparam logic [3:0]        NIBBLE_MASK       = 4'hf;

	typedef struct packed {
		logic [2:0]  column;
		logic [7:0]  weight_pair;
		logic [63:0] acts_even;
		logic [63:0] acts_odd;
		logic        first;
		logic        finish;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        row;
		logic [2:0]        out_column;
		logic signed [31:0] sum;
		logic              end_of_run;
	} out_item_t;

	typedef logic [ACT_ROWS-1:0][ACC_W-1:0] sum_vec_t;

	// item plus the per-row sums filled in as it walks the chain
	typedef struct packed {
		in_item_t item;
		sum_vec_t sums;
	} chain_t;

endpackage

@@ rtl/core/igemv_cell.sv @@
// One row cell: holds that row's accumulators for every column.
// Adds low*even + high*odd for its row and passes the item to the next cell.
// Depends on igemv_pkg.
module igemv_cell import igemv_pkg::*; #(
	parameter int ROW_IDX = 0,
	parameter int DEPTH   = 8
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   adv,
	input  logic   in_vld,
	input  chain_t in_data,
	output logic   out_vld,
	output chain_t out_data
);

	localparam int CW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam bit FILL = (ROW_IDX < ACT_ROWS);
	localparam int SLOT = FILL ? ROW_IDX : 0;

	logic [ACC_W-1:0] acc_q [DEPTH];
	logic             vld_s1;
	chain_t           data_s1;

	logic [CW-1:0]      col_idx;
	logic signed [3:0]  w_lo;
	logic signed [3:0]  w_hi;
	logic signed [7:0]  act_e;
	logic signed [7:0]  act_o;
	logic signed [11:0] prod_e;
	logic signed [11:0] prod_o;
	logic signed [12:0] dot;
	logic [ACC_W-1:0]   acc_base;
	logic [ACC_W-1:0]   acc_new;
	chain_t             nxt;

	always_comb begin
		col_idx  = in_data.item.column[CW-1:0];
		w_lo     = signed'(in_data.item.weight_pair[3:0] & NIBBLE_MASK);
		w_hi     = signed'(in_data.item.weight_pair[7:4] & NIBBLE_MASK);
		// rows past the eighth see zero activations
		act_e    = FILL ? signed'(in_data.item.acts_even[8*SLOT +: 8]) : '0;
		act_o    = FILL ? signed'(in_data.item.acts_odd[8*SLOT +: 8]) : '0;
		prod_e   = w_lo * act_e;
		prod_o   = w_hi * act_o;
		dot      = 13'(prod_e) + 13'(prod_o);
		acc_base = in_data.item.first ? '0 : acc_q[col_idx];
		acc_new  = acc_base + ACC_W'(dot);
		nxt      = in_data;
		if (FILL) begin
			nxt.sums[SLOT] = acc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int i = 0; i < DEPTH; i++) begin
				acc_q[i] <= '0;
			end
		end else if (adv) begin
			vld_s1 <= in_vld;
			if (in_vld) begin
				acc_q[col_idx] <= acc_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= nxt;
		end
	end

	assign out_vld  = vld_s1;
	assign out_data = data_s1;

endmodule

@@ rtl/core/igemv_emit.sv @@
// Result serializer: takes a finished column record from the chain tail
// and hands out one row sum per item on the result channel.
// Depends on igemv_pkg.
module igemv_emit import igemv_pkg::*; #(
	parameter int EMIT = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  chain_t    load_data,
	input  logic [3:0] active_rows,
	output logic      can_load,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic       busy_q;
	logic [2:0] row_q;
	logic [2:0] last_q;
	logic [2:0] col_q;
	sum_vec_t   sums_q;

	logic       take;
	logic       at_end;
	logic [3:0] n_rows;

	always_comb begin
		if (active_rows == 4'd0) begin
			n_rows = 4'd1;
		end else if (active_rows > 4'(EMIT)) begin
			n_rows = 4'(EMIT);
		end else begin
			n_rows = active_rows;
		end
	end

	assign take     = busy_q && result_ready;
	assign at_end   = (row_q == last_q);
	assign can_load = !busy_q || (take && at_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			row_q  <= '0;
		end else if (take) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else begin
				row_q <= row_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= 3'(n_rows - 4'd1);
			col_q  <= load_data.item.column;
			sums_q <= load_data.sums;
		end
	end

	assign result_valid = busy_q;
	always_comb begin
		result.row        = row_q;
		result.out_column = col_q;
		result.sum        = signed'(sums_q[row_q]);
		result.end_of_run = at_end;
	end

endmodule

@@ rtl/core/int4_weight_gemv_tile.sv @@
// Items walk the chain of ROWS row cells, one item per cycle, but a finish
// item at the tail stalls the chain until the serializer takes it, and the
// serializer emits one sum per row (active_rows clamped to 1..min(ROWS, 8)).
// Reset: asynchronous, active low; clears all accumulators, active_rows to 1.
// Depends on igemv_pkg, igemv_cell, igemv_emit.
module int4_weight_gemv_tile import igemv_pkg::*; #(
	parameter int ROWS    = 8,
	parameter int COLUMNS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  in_item_t          item,
	output logic              result_valid,
	input  logic              result_ready,
	output out_item_t         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int DEPTH = (COLUMNS < COL_SLOTS) ? COLUMNS : COL_SLOTS;
	localparam int EMIT  = (ROWS < ACT_ROWS) ? ROWS : ACT_ROWS;

	logic [3:0] active_rows_q;
	logic       adv;
	logic       can_load;
	logic       col_ok;
	logic       tail_fin;
	logic       link_vld [ROWS+1];
	chain_t     link     [ROWS+1];

	// configuration
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_rows_q <= ACTIVE_ROWS_RESET;
		end else if (psel && penable && pwrite && paddr == ADDR_ACTIVE_ROWS) begin
			active_rows_q <= pwdata[3:0];
		end
	end
	assign prdata = (paddr == ADDR_ACTIVE_ROWS) ? 32'(active_rows_q) : '0;

	// whole chain moves together; only a finish item waiting on the
	// serializer holds it
	assign tail_fin   = link_vld[ROWS] && link[ROWS].item.finish;
	assign adv        = !tail_fin || can_load;
	assign item_ready = adv;

	// out-of-range columns are taken and dropped
	assign col_ok      = int'(item.column) < COLUMNS;
	assign link_vld[0] = item_valid && col_ok;
	assign link[0]     = '{item: item, sums: '0};

	for (genvar r = 0; r < ROWS; r++) begin : g_row
		igemv_cell #(
			.ROW_IDX(r),
			.DEPTH  (DEPTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.in_vld  (link_vld[r]),
			.in_data (link[r]),
			.out_vld (link_vld[r+1]),
			.out_data(link[r+1])
		);
	end

	igemv_emit #(
		.EMIT(EMIT)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (tail_fin && can_load),
		.load_data   (link[ROWS]),
		.active_rows (active_rows_q),
		.can_load    (can_load),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

`ifndef SYNTHESIS
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result.end_of_run |=> result_valid)
		else $error("result run broke off before its last row");

	a_row_steps: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result.end_of_run
		|=> result.row == 3'($past(result.row) + 3'd1))
		else $error("result rows not consecutive");

	a_column_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> int'(result.out_column) < COLUMNS)
		else $error("result for a column outside the tile");

	a_tail_holds: assert property (@(posedge clk) disable iff (!arst_n)
		tail_fin && !can_load |-> !item_ready)
		else $error("chain advanced while finished item was blocked");

	a_row_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> int'(result.row) < EMIT)
		else $error("result row beyond the emitted rows");
`endif

endmodule

@@ dv/gemv_sum_board_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard for the int4-weight GEMV tile: keeps its own copy of the column
// sums and the active_rows setting, and checks emitted sums in order.
// Depends on igemv_pkg.
package gemv_sum_board_pkg;
	import igemv_pkg::*;

	class gemv_sum_board;
		bit [ACC_W-1:0] col_sums [COL_SLOTS][ACT_ROWS];
		bit [3:0]       rows_setting;
		out_item_t      sums_due [$];
		int             errors;

		function new();
			foreach (col_sums[c, r])
				col_sums[c][r] = '0;
			rows_setting = ACTIVE_ROWS_RESET;
			errors = 0;
		endfunction

		function void set_rows(bit [3:0] value);
			rows_setting = value;
		endfunction

		function int pending();
			return sums_due.size();
		endfunction

		// Called on every accepted item; queues the sums a finish item emits.
		function void accumulate_item(in_item_t it);
			int w_even;
			int w_odd;
			int a_even;
			int a_odd;
			int n_emit;
			bit [ACC_W-1:0] add;
			out_item_t e;

			if (it.column >= COL_SLOTS)
				return;
			w_even = $signed(it.weight_pair[3:0]);
			w_odd  = $signed(it.weight_pair[7:4]);
			for (int r = 0; r < ACT_ROWS; r++) begin
				a_even = $signed(it.acts_even[8*r +: 8]);
				a_odd  = $signed(it.acts_odd[8*r +: 8]);
				add = w_even * a_even + w_odd * a_odd;
				if (it.first)
					col_sums[it.column][r] = '0;
				col_sums[it.column][r] += add;
			end
			if (!it.finish)
				return;
			// zero reads as one, anything past the row count saturates
			n_emit = (rows_setting == 0) ? 1 : int'(rows_setting);
			if (n_emit > ACT_ROWS)
				n_emit = ACT_ROWS;
			for (int r = 0; r < n_emit; r++) begin
				e.row        = r[2:0];
				e.out_column = it.column;
				e.sum        = col_sums[it.column][r];
				e.end_of_run = (r == n_emit - 1);
				sums_due.push_back(e);
			end
		endfunction

		function void check_sum(out_item_t got);
			out_item_t e;

			if (sums_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected sum row %0d col %0d sum %0d end %0b",
					$time, got.row, got.out_column, got.sum, got.end_of_run);
				return;
			end
			e = sums_due.pop_front();
			if (got.row !== e.row || got.out_column !== e.out_column ||
					got.sum !== e.sum || got.end_of_run !== e.end_of_run) begin
				errors++;
				$display("%0t: mismatch exp %0d/%0d sum %0d end %0b, got %0d/%0d sum %0d end %0b",
					$time, e.row, e.out_column, e.sum, e.end_of_run,
					got.row, got.out_column, got.sum, got.end_of_run);
			end
		endfunction
	endclass

endpackage

@@ dv/int4_weight_gemv_tile_test.sv @@
`timescale 1ns / 100ps
// Testbench for int4_weight_gemv_tile: directed corner items, then random
// accumulate/finish runs under random stalls on both channels.
// Depends on igemv_pkg, gemv_sum_board_pkg and the tile RTL.
module int4_weight_gemv_tile_test;
	import igemv_pkg::*;
	import gemv_sum_board_pkg::*;

	localparam int TILE_ROWS      = 8;
	localparam int TILE_COLUMNS   = 8;
	localparam int CLK_PERIOD     = 10;
	localparam int TIMEOUT_CYCLES = 1500000;
	localparam int SETTLE_CYCLES  = TILE_ROWS + 4;
	localparam int LONG_HOLD      = 400;
	localparam int PHASES         = 6;
	localparam int PHASE_ITEMS    = 50;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	in_item_t          item;
	logic              result_valid;
	logic              result_ready;
	out_item_t         result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	gemv_sum_board sb;

	bit tx_gaps;
	bit rx_quiet;
	bit rx_hold_req;

	int4_weight_gemv_tile #(
		.ROWS(TILE_ROWS),
		.COLUMNS(TILE_COLUMNS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
		$display("FAIL int4_weight_gemv_tile");
		$finish;
	end

	always @(posedge clk) begin
		if (result_valid && result_ready)
			sb.check_sum(result);
	end

	// Receiver: random stalls, quiet stretches, and one long hold on request.
	initial begin : receiver
		int stall_left;
		int pick;

		stall_left = 0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				result_ready = 1'b0;
				stall_left--;
			end else if (rx_quiet) begin
				result_ready = 1'b1;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					result_ready = 1'b1;
				end else if (pick < 93) begin
					result_ready = 1'b0;
					stall_left = $urandom_range(0, 2);
				end else begin
					result_ready = 1'b0;
					stall_left = $urandom_range(8, 40);
				end
			end
		end
	end

	function automatic int pick_gap();
		int pick;

		if (!tx_gaps)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 65)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// Activations mix sign extremes, zero and -1 per row with plain random bytes.
	function automatic logic [63:0] rand_acts();
		logic [63:0] acts;

		if ($urandom_range(0, 7) == 0)
			return {$urandom, $urandom};
		for (int r = 0; r < ACT_ROWS; r++) begin
			case ($urandom_range(0, 5))
				0: acts[8*r +: 8] = 8'h80;
				1: acts[8*r +: 8] = 8'h7f;
				2: acts[8*r +: 8] = 8'hff;
				3: acts[8*r +: 8] = 8'h00;
				default: acts[8*r +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		return acts;
	endfunction

	function automatic logic [7:0] rand_weights();
		case ($urandom_range(0, 9))
			0: return 8'h88;
			1: return 8'h77;
			2: return 8'h08;
			3: return 8'h80;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	// with item_valid still high.
	task automatic send_item(input logic [2:0] col, input logic [7:0] wp,
			input logic [63:0] ae, input logic [63:0] ao,
			input logic fst, input logic fin);
		int gap;
		in_item_t it;

		it.column      = col;
		it.weight_pair = wp;
		it.acts_even   = ae;
		it.acts_odd    = ao;
		it.first       = fst;
		it.finish      = fin;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item = it;
		item_valid = 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		sb.accumulate_item(it);
		@(negedge clk);
	endtask

	task automatic send_rand(input logic [2:0] col, input logic fst, input logic fin);
		send_item(col, rand_weights(), rand_acts(), rand_acts(), fst, fin);
	endtask

	// Stop offering, wait for every queued sum, then let the row chain empty.
	task automatic drain();
		item_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_active_rows(input logic [3:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_ACTIVE_ROWS;
		pwdata  = {28'($urandom_range(0, 32'h0fff_ffff)), value};
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.set_rows(value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Mostly first..finish runs on one column, some items with random flags.
	task automatic random_phase(input int n_items);
		int sent;
		int len;
		logic [2:0] col;

		sent = 0;
		while (sent < n_items) begin
			col = 3'($urandom_range(0, TILE_COLUMNS - 1));
			if ($urandom_range(0, 4) == 0) begin
				send_rand(col, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				sent++;
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16)
					: $urandom_range(1, 5);
				for (int k = 0; k < len; k++)
					send_rand(col, k == 0, k == len - 1);
				sent += len;
			end
		end
	endtask

	initial begin : stimulus
		logic [3:0] rows_plan [PHASES];

		sb = new();
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		item        = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		tx_gaps     = 1'b0;
		rx_quiet    = 1'b1;
		rx_hold_req = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset value of active_rows, one sum per finish
		send_item(3'd0, 8'h88, {8{8'h80}}, {8{8'h80}}, 1'b1, 1'b1);
		send_item(3'd1, 8'h77, {8{8'h7f}}, {8{8'h7f}}, 1'b1, 1'b0);
		send_item(3'd1, 8'h80, rand_acts(), rand_acts(), 1'b0, 1'b1);
		drain();
		write_active_rows(4'd8);
		send_item(3'd7, 8'h77, {8{8'h7f}}, {8{8'h7f}}, 1'b1, 1'b1);
		send_item(3'd3, 8'h78, {8{8'h7f}}, {8{8'h80}}, 1'b1, 1'b0);
		send_item(3'd3, 8'h0f, rand_acts(), rand_acts(), 1'b0, 1'b0);
		send_item(3'd3, 8'hf0, rand_acts(), rand_acts(), 1'b0, 1'b1);
		// finish on a column that still holds sums from the first item
		send_item(3'd0, 8'h11, 64'h80_7f_01_ff_00_40_c0_81, 64'h7f_80_ff_01_c0_00_81_40,
			1'b0, 1'b1);
		send_item(3'd5, 8'h00, {8{8'hff}}, {8{8'hff}}, 1'b1, 1'b1);
		// two columns interleaved
		send_item(3'd2, 8'h8f, rand_acts(), rand_acts(), 1'b1, 1'b0);
		send_item(3'd6, 8'hf8, rand_acts(), rand_acts(), 1'b1, 1'b0);
		send_item(3'd2, 8'h07, rand_acts(), rand_acts(), 1'b0, 1'b1);
		send_item(3'd6, 8'h70, rand_acts(), rand_acts(), 1'b0, 1'b1);
		send_item(3'd4, 8'hff, {8{8'h01}}, {8{8'hff}}, 1'b1, 1'b1);
		drain();
		write_active_rows(4'd0);
		send_item(3'd7, 8'h9a, rand_acts(), rand_acts(), 1'b0, 1'b1);
		send_item(3'd7, 8'h88, {8{8'h80}}, {8{8'h7f}}, 1'b1, 1'b1);
		drain();
		write_active_rows(4'd15);
		send_item(3'd4, 8'h5c, rand_acts(), rand_acts(), 1'b0, 1'b1);
		send_item(3'd1, 8'h80, rand_acts(), rand_acts(), 1'b1, 1'b1);
		send_item(3'd1, 8'h08, rand_acts(), rand_acts(), 1'b0, 1'b1);
		drain();
		write_active_rows(4'd3);
		send_item(3'd0, 8'ha5, rand_acts(), rand_acts(), 1'b1, 1'b1);
		send_item(3'd0, 8'h5a, rand_acts(), rand_acts(), 1'b0, 1'b1);

		rows_plan[0] = 4'd1;
		rows_plan[1] = 4'd8;
		rows_plan[2] = 4'd8;
		rows_plan[3] = 4'd0;
		rows_plan[4] = 4'($urandom_range(9, 15));
		rows_plan[5] = 4'($urandom_range(2, 7));
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_active_rows(rows_plan[ph]);
			tx_gaps  = (ph != 1);
			rx_quiet = (ph == 4);
			// long receiver hold while items keep coming
			if (ph == 2)
				rx_hold_req = 1'b1;
			random_phase(PHASE_ITEMS);
		end
		drain();

		if (sb.errors == 0)
			$display("PASS int4_weight_gemv_tile");
		else
			$display("FAIL int4_weight_gemv_tile");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/igemv_pkg.sv
rtl/core/igemv_cell.sv
rtl/core/igemv_emit.sv
rtl/core/int4_weight_gemv_tile.sv
dv/gemv_sum_board_pkg.sv
dv/int4_weight_gemv_tile_test.sv
